// File: sv/bsr_pkg.sv
package bsr_pkg;

	localparam int unsigned RAD_W  = 64;
	localparam int unsigned ROOT_W = 32;
	// one restoring step per result bit
	localparam int unsigned N_ITER = ROOT_W;

	typedef enum logic [1:0] {
		MODE_INT     = 2'd0,
		MODE_FIX     = 2'd1,
		MODE_FIX_LOW = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// control that travels with each item down the pipe
	typedef struct packed {
		logic  valid;
		mode_t mode;
	} stage_ctl_t;

endpackage

// File: sv/bsr_prep.sv
module bsr_prep
	import bsr_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  logic [1:0]          mode,
	input  logic [RAD_W-1:0]    radicand,
	output stage_ctl_t          ctl_s1,
	output logic [RAD_W-1:0]    rem_s1
);

	mode_t            mode_m;
	logic [RAD_W-1:0] operand;
	logic             valid_s1;
	mode_t            mode_s1;

	assign mode_m = mode_t'(mode);
	assign ctl_s1 = '{valid: valid_s1, mode: mode_s1};

	// operand selection per mode
	always_comb begin
		case (mode_m)
			MODE_INT:     operand = radicand;
			MODE_FIX:     operand = {32'b0, radicand[31:0]} << FRAC_BITS;
			MODE_FIX_LOW: operand = {33'b0, radicand[30:0]};
			default:      operand = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_m;
			rem_s1  <= operand;
		end
	end

endmodule

// File: sv/bsr_iter.sv
module bsr_iter
	import bsr_pkg::*;
#(
	parameter int unsigned BIT = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  stage_ctl_t          ctl_prev,
	input  logic [RAD_W-1:0]    rem_prev,
	input  logic [ROOT_W-1:0]   root_prev,
	output stage_ctl_t          ctl_sn,
	output logic [RAD_W-1:0]    rem_sn,
	output logic [ROOT_W-1:0]   root_sn
);

	logic [RAD_W-1:0] trial;
	logic             fits;
	logic             valid_sn;
	mode_t            mode_sn;

	// (2*root + 2^bit) << bit; the two terms never overlap
	assign trial = ({32'b0, root_prev} << (BIT + 1)) | (64'd1 << (2 * BIT));
	assign fits  = (trial <= rem_prev);

	assign ctl_sn = '{valid: valid_sn, mode: mode_sn};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= ctl_prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_sn <= ctl_prev.mode;
			rem_sn  <= fits ? (rem_prev - trial) : rem_prev;
			root_sn <= root_prev | (ROOT_W'(fits) << BIT);
		end
	end

endmodule

// File: sv/bsr_post.sv
module bsr_post
	import bsr_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  stage_ctl_t          ctl_prev,
	input  logic [ROOT_W-1:0]   root_prev,
	output logic                valid_q,
	output logic [ROOT_W-1:0]   root_q
);

	localparam int unsigned HALF_FRAC = FRAC_BITS / 2;

	logic [ROOT_W-1:0] result;

	always_comb begin
		case (ctl_prev.mode) inside
			MODE_INT, MODE_FIX: result = root_prev;
			MODE_FIX_LOW:       result = root_prev << HALF_FRAC;
			default:            result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= result;
		end
	end

endmodule

// File: sv/bitwise_square_root_top.sv
// channel   | valid       | stall       | payload
// radicand  | rad_valid   | rad_stall   | mode[1:0], radicand[63:0]
// root      | root_valid  | root_stall  | root[31:0]
//
// one item enters per cycle while rad_stall is low; a taken item passes through
// one operand stage, 32 restoring stages and one output stage before its root leaves
// every restoring stage settles one root bit with one 64-bit compare-subtract
// arst_n clears every valid bit; payload registers are not reset
// a stage holds only while it is full and the one after it holds too, so
// bubbles are squeezed out and rad_stall rises only when the whole pipe is full
module bitwise_square_root_top
	import bsr_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rad_valid,
	output logic                rad_stall,
	input  logic [1:0]          mode,
	input  logic [RAD_W-1:0]    radicand,
	output logic                root_valid,
	input  logic                root_stall,
	output logic [ROOT_W-1:0]   root
);

	// stage 0 is the operand register, stages 1..N_ITER the restoring steps
	stage_ctl_t        ctl   [0:N_ITER];
	logic [RAD_W-1:0]  rem   [0:N_ITER];
	logic [ROOT_W-1:0] roots [0:N_ITER];
	// en[N_ITER+1] drives the output register
	logic [N_ITER+1:0] en;

	assign roots[0] = '0;

	// advance when empty or when the next stage advances too
	// worked out from the output end so each stage sees the one after it
	always_comb begin
		en[N_ITER+1] = !root_valid || !root_stall;
		for (int k = N_ITER; k >= 0; k--) begin
			en[k] = !ctl[k].valid || en[k+1];
		end
	end

	assign rad_stall = !en[0];

	bsr_prep #(
		.FRAC_BITS (FRAC_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[0]),
		.valid    (rad_valid),
		.mode     (mode),
		.radicand (radicand),
		.ctl_s1   (ctl[0]),
		.rem_s1   (rem[0])
	);

	// root bits from most significant down, one per stage
	for (genvar g = 1; g <= N_ITER; g++) begin : g_iter
		bsr_iter #(
			.BIT (N_ITER - g)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en[g]),
			.ctl_prev  (ctl[g-1]),
			.rem_prev  (rem[g-1]),
			.root_prev (roots[g-1]),
			.ctl_sn    (ctl[g]),
			.rem_sn    (rem[g]),
			.root_sn   (roots[g])
		);
	end

	// final remainder is not needed past the last step
	bsr_post #(
		.FRAC_BITS (FRAC_BITS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en[N_ITER+1]),
		.ctl_prev  (ctl[N_ITER]),
		.root_prev (roots[N_ITER]),
		.valid_q   (root_valid),
		.root_q    (root)
	);

endmodule

// File: sv/bsr_checker.sv
module bsr_checker
	import bsr_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                rad_valid,
	input logic                rad_stall,
	input logic [1:0]          mode,
	input logic [RAD_W-1:0]    radicand,
	input logic                root_valid,
	input logic                root_stall,
	input logic [ROOT_W-1:0]   root
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && root_stall |=> root_valid && $stable(root))
		else $error("root changed while stalled");

	// a held input item keeps its value
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rad_valid && rad_stall |=> rad_valid && $stable(mode) && $stable(radicand))
		else $error("input item changed while stalled");

	// input only held back when the pipe is full and the output stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		rad_stall |-> root_valid && root_stall)
		else $error("input stalled with room in the pipe");

	// nothing leaves right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !root_valid)
		else $error("result present straight after reset");

	// a free output never leaves the input stalled in the same cycle
	a_no_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		!root_stall |-> !rad_stall)
		else $error("input stalled while output free");

endmodule

bind bitwise_square_root_top bsr_checker u_bsr_checker (.*);

// File: test/bitwise_square_root_top_tb.sv
module bitwise_square_root_top_tb
	import bsr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// fraction bits the block is built with, shared with the predictor
	localparam int unsigned FRAC_BITS = 16;
	// pipe depth is 34 stages, so this covers every root still in flight
	localparam int DRAIN_CYCLES = 60;
	// several times the slowest correct run, with both sides idling the longest between items
	localparam int CYCLE_LIMIT = 400000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              rad_valid = 1'b0;
	logic              rad_stall;
	logic [1:0]        mode = MODE_INT;
	logic [RAD_W-1:0]  radicand = '0;
	logic              root_valid;
	logic              root_stall = 1'b0;
	logic [ROOT_W-1:0] root;

	// roots still owed by the block, oldest first
	logic [ROOT_W-1:0] pending_roots[$];
	int                mismatch_count = 0;
	int                cycle_count = 0;
	// longest wait each side may draw before an item; 0 gives back-to-back traffic
	int                rad_gap_max = 18;
	int                sink_gap_max = 18;

	bitwise_square_root_top #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rad_valid (rad_valid),
		.rad_stall (rad_stall),
		.mode      (mode),
		.radicand  (radicand),
		.root_valid(root_valid),
		.root_stall(root_stall),
		.root      (root)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// restoring digit-by-digit root, most significant root bit first
	function automatic logic [RAD_W-1:0] square_root_floor(input logic [RAD_W-1:0] value);
		logic [RAD_W-1:0] rest;
		logic [RAD_W-1:0] acc;
		logic [RAD_W-1:0] trial;
		rest = value;
		acc = '0;
		for (int s = ROOT_W - 1; s >= 0; s--) begin
			trial = ((acc << 1) + (64'd1 << s)) << s;
			if (trial <= rest) begin
				acc = acc + (64'd1 << s);
				rest = rest - trial;
			end
		end
		return acc;
	endfunction

	function automatic logic [ROOT_W-1:0] predicted_root(input mode_t m,
			input logic [RAD_W-1:0] rad);
		logic [RAD_W-1:0] wide;
		case (m)
			MODE_INT: begin
				wide = square_root_floor(rad);
			end
			MODE_FIX: begin
				// high word ignored, low word scaled up before the root
				wide = square_root_floor({32'd0, rad[31:0]} << FRAC_BITS);
			end
			MODE_FIX_LOW: begin
				// root of the low 31 bits, then scaled by half the fraction bits
				wide = square_root_floor({33'd0, rad[30:0]}) << (FRAC_BITS / 2);
			end
			default: begin
				wide = '0;
			end
		endcase
		return wide[ROOT_W-1:0];
	endfunction

	function automatic int draw_wait(input int max_wait);
		return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
	endfunction

	// mostly meaningful modes, the unused one now and then
	function automatic mode_t random_mode();
		int pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0, 1, 2: return MODE_INT;
			3, 4:    return MODE_FIX;
			5, 6:    return MODE_FIX_LOW;
			default: return MODE_NONE;
		endcase
	endfunction

	function automatic logic [RAD_W-1:0] random_radicand(input mode_t m);
		logic [RAD_W-1:0] rad;
		logic [RAD_W-1:0] base;
		int               shape;
		shape = $urandom_range(0, 3);
		case (shape)
			0: begin
				rad = {$urandom, $urandom};
			end
			1: begin
				// random magnitude so that short roots get their share
				rad = {$urandom, $urandom} >> $urandom_range(0, 63);
			end
			2: begin
				// perfect squares and their neighbours, where the root steps
				base = 64'($urandom) >> $urandom_range(0, 31);
				if (m == MODE_FIX_LOW)
					base = base % 46341;
				else if (m == MODE_FIX)
					base = base & 64'hFFFF;
				rad = base * base + 64'($urandom_range(0, 2)) - 64'd1;
			end
			default: begin
				rad = 64'($urandom_range(0, 300));
			end
		endcase
		// bits above the used field must not matter in the fixed-point modes
		if (m == MODE_FIX_LOW && $urandom_range(0, 1))
			rad[RAD_W-1:31] = {$urandom, 1'($urandom)};
		else if (m == MODE_FIX && $urandom_range(0, 1))
			rad[RAD_W-1:32] = $urandom;
		return rad;
	endfunction

	// present one item, hold it while stalled, log its root once taken
	task automatic send_radicand(input mode_t m, input logic [RAD_W-1:0] rad);
		int gap;
		gap = draw_wait(rad_gap_max);
		if (gap > 0) begin
			rad_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rad_valid <= 1'b1;
		mode <= m;
		radicand <= rad;
		do @(posedge clk); while (rad_stall);
		pending_roots.push_back(predicted_root(m, rad));
	endtask

	// result side: random stall before each root, then take it
	initial begin : root_sink
		int hold;
		forever begin
			hold = draw_wait(sink_gap_max);
			if (hold > 0) begin
				root_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			root_stall <= 1'b0;
			do @(posedge clk); while (!root_valid);
		end
	end

	// every root taken is compared with the oldest one owed
	always @(posedge clk) begin : root_check
		logic [ROOT_W-1:0] want;
		if (arst_n && root_valid && !root_stall) begin
			if (pending_roots.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected root item, expected none, actual %h",
					$time, root);
			end else begin
				want = pending_roots.pop_front();
				if (root !== want) begin
					mismatch_count++;
					$display("%0t: root mismatch, expected %h, actual %h",
						$time, want, root);
				end
			end
		end
	end

	// hard stop if the pipe hangs or roots go missing
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// extremes of every mode, exact squares either side, ignored high bits
	task automatic test_directed_corners();
		rad_gap_max = 18;
		sink_gap_max = 18;
		send_radicand(MODE_INT, 64'd0);
		send_radicand(MODE_INT, 64'd1);
		send_radicand(MODE_INT, 64'd2);
		send_radicand(MODE_INT, 64'd3);
		send_radicand(MODE_INT, 64'd4);
		send_radicand(MODE_INT, 64'hFFFF_FFFE_0000_0001);
		send_radicand(MODE_INT, 64'hFFFF_FFFE_0000_0000);
		send_radicand(MODE_INT, 64'h4000_0000_0000_0000);
		send_radicand(MODE_INT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_radicand(MODE_FIX, 64'd0);
		send_radicand(MODE_FIX, 64'd1);
		send_radicand(MODE_FIX, 64'h0000_0000_FFFF_FFFF);
		// high word set but ignored
		send_radicand(MODE_FIX, 64'hFFFF_FFFF_FFFF_FFFF);
		send_radicand(MODE_FIX, 64'hFFFF_FFFF_0000_0000);
		send_radicand(MODE_FIX_LOW, 64'd0);
		send_radicand(MODE_FIX_LOW, 64'd1);
		send_radicand(MODE_FIX_LOW, 64'h0000_0000_7FFF_FFFF);
		// bit 31 upwards ignored
		send_radicand(MODE_FIX_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		send_radicand(MODE_FIX_LOW, 64'h0000_0000_8000_0000);
		send_radicand(MODE_FIX_LOW, 64'd2147395600);
		send_radicand(MODE_FIX_LOW, 64'd2147395599);
		// unused mode gives a zero root
		send_radicand(MODE_NONE, 64'd0);
		send_radicand(MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic send_random_batch(input int count);
		mode_t m;
		for (int i = 0; i < count; i++) begin
			m = random_mode();
			send_radicand(m, random_radicand(m));
		end
	endtask

	// random items with both sides idling
	task automatic test_random_radicands();
		rad_gap_max = 18;
		sink_gap_max = 18;
		send_random_batch(600);
	endtask

	// sender never idles, sink stalls: pipe fills and rad_stall must hold items
	task automatic test_sink_backpressure();
		rad_gap_max = 0;
		sink_gap_max = 18;
		send_random_batch(200);
	endtask

	// sparse items into an always-ready sink: bubbles all through the pipe
	task automatic test_sender_gaps();
		rad_gap_max = 18;
		sink_gap_max = 0;
		send_random_batch(150);
	endtask

	// full rate, one item per cycle each way
	task automatic test_streaming();
		rad_gap_max = 0;
		sink_gap_max = 0;
		send_random_batch(180);
	endtask

	initial begin : main_flow
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_radicands();
		test_sink_backpressure();
		test_sender_gaps();
		test_streaming();
		rad_valid <= 1'b0;
		// let the sink stall only briefly so the tail drains quickly
		sink_gap_max = 4;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_roots.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
